// ===== rtl/tbd_pkg.sv =====
// ----------------------------------------------------------------------------
// tbd_pkg
// shared types and constants for the touch button decoder
// ----------------------------------------------------------------------------
`default_nettype none

package tbd_pkg;

  // raw conversion and position widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 16;

  // stream widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 40;

  // apb
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  // calibration defaults
  localparam logic signed [CFG_W-1:0] DEFAULT_X_GAIN   = 16'sd12316;
  localparam logic signed [CFG_W-1:0] DEFAULT_X_OFFSET = -16'sd43;
  localparam logic signed [CFG_W-1:0] DEFAULT_Y_GAIN   = -16'sd8981;
  localparam logic signed [CFG_W-1:0] DEFAULT_Y_OFFSET = 16'sd257;

  localparam logic [CFG_W-1:0] HOLD_OFF_RESET = 16'd250;

  // button strip and zone bounds, inclusive
  localparam logic [POS_W-1:0] STRIP_Y_LO = 16'd185;
  localparam logic [POS_W-1:0] STRIP_Y_HI = 16'd224;
  localparam logic [POS_W-1:0] BACK_X_LO  = 16'd21;
  localparam logic [POS_W-1:0] BACK_X_HI  = 16'd98;
  localparam logic [POS_W-1:0] FWD_X_LO   = 16'd121;
  localparam logic [POS_W-1:0] FWD_X_HI   = 16'd198;
  localparam logic [POS_W-1:0] SEL_X_LO   = 16'd221;
  localparam logic [POS_W-1:0] SEL_X_HI   = 16'd298;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_BACK   = 2'd1,
    ACT_FWD    = 2'd2,
    ACT_SELECT = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_X_GAIN   = 3'd0,
    REG_X_OFFSET = 3'd1,
    REG_Y_GAIN   = 3'd2,
    REG_Y_OFFSET = 3'd3,
    REG_HOLD_OFF = 3'd4
  } reg_idx_t;

  // one axis calibration pair
  typedef struct packed {
    logic signed [CFG_W-1:0] gain;
    logic signed [CFG_W-1:0] offset;
  } axis_cal_t;

endpackage

`default_nettype wire

// ===== rtl/touch_button_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// touch_button_decoder_unit
// turns one resistive touch panel poll into a button action and position
// ----------------------------------------------------------------------------
// Each request on the slave stream is one poll: a millisecond time stamp, the
// pen line before and after sampling, and three raw 12-bit conversions per
// axis. Every poll yields exactly one result on the master stream. A poll
// whose time is below the stored deadline yields action none with zero
// positions and leaves the deadline alone; any other poll moves the deadline
// to its time plus hold_off_ms (wrapping at 2^32). With the pen down at both
// checks each axis averages its two closest samples, scales by the gain
// (bits 31:16 of the wrapped product) and adds the offset; if x_gain plus
// x_offset is zero the built-in default calibration is used for both axes.
// The position is then matched against three button zones in one y strip.
// Timing: a poll enters an input register and is decoded combinationally into
// the result register; one poll is taken every cycle while the result stream
// does not stall, with the deadline compare-and-update as the loop behind this.
// Configuration registers sit on an apb port at byte addresses 0, 4, 8, 12, 16
// (x_gain, x_offset, y_gain, y_offset, hold_off_ms); the user must write them
// only while the block is idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_button_decoder_unit #(
  parameter logic signed [15:0] DEFAULT_X_GAIN   = tbd_pkg::DEFAULT_X_GAIN,
  parameter logic signed [15:0] DEFAULT_X_OFFSET = tbd_pkg::DEFAULT_X_OFFSET,
  parameter logic signed [15:0] DEFAULT_Y_GAIN   = tbd_pkg::DEFAULT_Y_GAIN,
  parameter logic signed [15:0] DEFAULT_Y_OFFSET = tbd_pkg::DEFAULT_Y_OFFSET
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // poll stream
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // now_ms[31:0], pen_up_before[32], x_sample_a[44:33], x_sample_b[56:45],
  // x_sample_c[68:57], y_sample_a[80:69], y_sample_b[92:81],
  // y_sample_c[104:93], pen_up_after[105], zero pad[111:106]
  input  wire logic [tbd_pkg::IN_DATA_W-1:0]     s_tdata,
  // result stream
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // action[1:0], x_position[17:2], y_position[33:18], zero pad[39:34]
  output logic [tbd_pkg::OUT_DATA_W-1:0]         m_tdata,
  // configuration
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tbd_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [tbd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tbd_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready
);

  localparam int unsigned SW = tbd_pkg::SAMPLE_W;
  localparam int unsigned PW = tbd_pkg::POS_W;
  localparam int unsigned TW = tbd_pkg::TIME_W;
  localparam int unsigned CW = tbd_pkg::CFG_W;

  // ---------------- configuration registers ----------------
  logic signed [CW-1:0] x_gain, x_offset, y_gain, y_offset;
  logic [CW-1:0]        hold_off_ms;
  logic                 cfg_write;
  logic [2:0]           reg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      x_gain      <= '0;
      x_offset    <= '0;
      y_gain      <= '0;
      y_offset    <= '0;
      hold_off_ms <= tbd_pkg::HOLD_OFF_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        tbd_pkg::REG_X_GAIN:   x_gain      <= pwdata[CW-1:0];
        tbd_pkg::REG_X_OFFSET: x_offset    <= pwdata[CW-1:0];
        tbd_pkg::REG_Y_GAIN:   y_gain      <= pwdata[CW-1:0];
        tbd_pkg::REG_Y_OFFSET: y_offset    <= pwdata[CW-1:0];
        tbd_pkg::REG_HOLD_OFF: hold_off_ms <= pwdata[CW-1:0];
        default: ;  // unmapped addresses drop the write
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tbd_pkg::REG_X_GAIN:   prdata = {16'd0, x_gain};
      tbd_pkg::REG_X_OFFSET: prdata = {16'd0, x_offset};
      tbd_pkg::REG_Y_GAIN:   prdata = {16'd0, y_gain};
      tbd_pkg::REG_Y_OFFSET: prdata = {16'd0, y_offset};
      tbd_pkg::REG_HOLD_OFF: prdata = {16'd0, hold_off_ms};
      default:               prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic in_valid;
  logic advance;     // input register moves into result register

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register, payload held without reset
  logic [TW-1:0] now_ms;
  logic          pen_up_before, pen_up_after;
  logic [SW-1:0] xs_a, xs_b, xs_c, ys_a, ys_b, ys_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      now_ms        <= s_tdata[31:0];
      pen_up_before <= s_tdata[32];
      xs_a          <= s_tdata[44:33];
      xs_b          <= s_tdata[56:45];
      xs_c          <= s_tdata[68:57];
      ys_a          <= s_tdata[80:69];
      ys_b          <= s_tdata[92:81];
      ys_c          <= s_tdata[104:93];
      pen_up_after  <= s_tdata[105];
    end
  end

  // ---------------- decode ----------------
  logic [TW-1:0]      next_allowed_ms;
  logic               early;
  logic               touched;
  logic [CW:0]        cal_sum;
  logic               use_default;
  tbd_pkg::axis_cal_t x_cal, y_cal;
  logic [PW-1:0]      x_pos, y_pos;
  tbd_pkg::action_t   zone_act;

  assign early   = now_ms < next_allowed_ms;
  assign touched = !pen_up_before && !pen_up_after;

  // exact 17-bit sum, zero selects the built-in calibration
  assign cal_sum     = {x_gain[CW-1], x_gain} + {x_offset[CW-1], x_offset};
  assign use_default = (cal_sum == '0);

  always_comb begin
    if (use_default) begin
      x_cal = '{gain: DEFAULT_X_GAIN, offset: DEFAULT_X_OFFSET};
      y_cal = '{gain: DEFAULT_Y_GAIN, offset: DEFAULT_Y_OFFSET};
    end else begin
      x_cal = '{gain: x_gain, offset: x_offset};
      y_cal = '{gain: y_gain, offset: y_offset};
    end
  end

  tbd_axis u_x_axis (
    .sample_a (xs_a),
    .sample_b (xs_b),
    .sample_c (xs_c),
    .cal      (x_cal),
    .position (x_pos)
  );

  tbd_axis u_y_axis (
    .sample_a (ys_a),
    .sample_b (ys_b),
    .sample_c (ys_c),
    .cal      (y_cal),
    .position (y_pos)
  );

  // button zones, all inside one y strip
  always_comb begin
    zone_act = tbd_pkg::ACT_NONE;
    if (y_pos >= tbd_pkg::STRIP_Y_LO && y_pos <= tbd_pkg::STRIP_Y_HI) begin
      priority if (x_pos >= tbd_pkg::BACK_X_LO && x_pos <= tbd_pkg::BACK_X_HI) begin
        zone_act = tbd_pkg::ACT_BACK;
      end else if (x_pos >= tbd_pkg::FWD_X_LO && x_pos <= tbd_pkg::FWD_X_HI) begin
        zone_act = tbd_pkg::ACT_FWD;
      end else if (x_pos >= tbd_pkg::SEL_X_LO && x_pos <= tbd_pkg::SEL_X_HI) begin
        zone_act = tbd_pkg::ACT_SELECT;
      end else begin
        zone_act = tbd_pkg::ACT_NONE;
      end
    end
  end

  // deadline moves for every poll that is not early, pen down or not
  always_ff @(posedge clk) begin
    if (rst) begin
      next_allowed_ms <= '0;
    end else if (advance && !early) begin
      next_allowed_ms <= now_ms + {{(TW-CW){1'b0}}, hold_off_ms};
    end
  end

  // ---------------- result register ----------------
  tbd_pkg::action_t res_action;
  logic [PW-1:0]    res_x, res_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (!early && touched) begin
        res_action <= zone_act;
        res_x      <= x_pos;
        res_y      <= y_pos;
      end else begin
        res_action <= tbd_pkg::ACT_NONE;
        res_x      <= '0;
        res_y      <= '0;
      end
    end
  end

  assign m_tdata = {6'd0, res_y, res_x, res_action};

endmodule

`default_nettype wire

// ===== rtl/tbd_axis.sv =====
// ----------------------------------------------------------------------------
// tbd_axis
// closest pair filter and gain/offset scaling for one axis
// ----------------------------------------------------------------------------
`default_nettype none

module tbd_axis (
  input  wire logic [tbd_pkg::SAMPLE_W-1:0] sample_a,
  input  wire logic [tbd_pkg::SAMPLE_W-1:0] sample_b,
  input  wire logic [tbd_pkg::SAMPLE_W-1:0] sample_c,
  input  wire tbd_pkg::axis_cal_t           cal,
  output logic      [tbd_pkg::POS_W-1:0]    position
);

  localparam int unsigned SW = tbd_pkg::SAMPLE_W;
  localparam int unsigned PW = tbd_pkg::SAMPLE_W + tbd_pkg::CFG_W + 1;

  logic [SW-1:0]        d_ab, d_ac, d_bc;
  logic [SW:0]          pair_sum;
  logic [SW-1:0]        filtered;
  logic signed [PW-1:0] prod;
  logic [tbd_pkg::POS_W-1:0] prod_hi;

  always_comb begin
    d_ab = (sample_a > sample_b) ? sample_a - sample_b : sample_b - sample_a;
    d_ac = (sample_a > sample_c) ? sample_a - sample_c : sample_c - sample_a;
    d_bc = (sample_b > sample_c) ? sample_b - sample_c : sample_c - sample_b;
    priority if (d_ab <= d_ac && d_ab <= d_bc) begin
      pair_sum = {1'b0, sample_a} + {1'b0, sample_b};
    end else if (d_ac <= d_bc) begin
      pair_sum = {1'b0, sample_a} + {1'b0, sample_c};
    end else begin
      pair_sum = {1'b0, sample_b} + {1'b0, sample_c};
    end
    filtered = pair_sum[SW:1];
  end

  // raw is non-negative, so the exact 29-bit product sign-extended is the
  // wrapped 32-bit product
  assign prod    = $signed({1'b0, filtered}) * cal.gain;
  assign prod_hi = {{(tbd_pkg::POS_W - (PW - 16)){prod[PW-1]}}, prod[PW-1:16]};
  assign position = prod_hi + cal.offset;

endmodule

`default_nettype wire

// ===== dv/tb_touch_button_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_touch_button_decoder_unit
// self-checking stream testbench for the touch button decoder
// ----------------------------------------------------------------------------
// Polls go in on the slave stream and every one of them must come back as one
// result on the master stream. A behavioral predictor keeps its own deadline
// and calibration copy and works out each result when the poll is accepted.
// A short directed table covers the hold-off boundary, pen-up cases, the
// filter's tie rules, all three buttons and deadline wrap. Random phases
// under several calibration settings (extremes, fallback, constant position)
// follow. The sender idles in bursts and the receiver stalls in patterns,
// with one long receiver hold-off and one full drain per phase.
// ----------------------------------------------------------------------------

module tb_touch_button_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // calibration used when x gain plus x offset is zero
  localparam logic [15:0] FALLBACK_X_GAIN   = 16'd12316;
  localparam logic [15:0] FALLBACK_X_OFFSET = 16'hFFD5;
  localparam logic [15:0] FALLBACK_Y_GAIN   = 16'hDCEB;
  localparam logic [15:0] FALLBACK_Y_OFFSET = 16'd257;

  // button strip and zones, strict bounds on x
  localparam logic [15:0] BAND_Y_MIN = 16'd185;
  localparam logic [15:0] BAND_Y_MAX = 16'd224;

  localparam int RANDOM_POLLS = 950;
  localparam int PHASES       = 6;
  localparam int LONG_STALL   = 300;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        pen_up_before;
    logic [11:0] x_a;
    logic [11:0] x_b;
    logic [11:0] x_c;
    logic [11:0] y_a;
    logic [11:0] y_b;
    logic [11:0] y_c;
    logic        pen_up_after;
  } poll_t;

  typedef struct packed {
    tbd_pkg::action_t action;
    logic [15:0]      x_pos;
    logic [15:0]      y_pos;
  } result_t;

  typedef struct packed {
    poll_t   poll;
    bit      typed;
    result_t want;
  } dir_row_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PULSE} sink_mode_e;

  localparam bit      TYPED       = 1'b1;
  localparam bit      PREDICT     = 1'b0;
  localparam result_t IDLE_RESULT = '{tbd_pkg::ACT_NONE, 16'd0, 16'd0};

  // directed polls, reset calibration (fallback active), hold-off 250
  localparam dir_row_t DIRECTED [21] = '{
    // first poll at time zero, all samples zero: offsets only
    '{'{32'd0, 1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 1'b0},
      TYPED, '{tbd_pkg::ACT_NONE, 16'hFFD5, 16'h0101}},
    // one ms before the deadline
    '{'{32'd249, 1'b0, 12'd400, 12'd400, 12'd400, 12'd400, 12'd400, 12'd400, 1'b0},
      TYPED, IDLE_RESULT},
    // on the deadline but pen up before sampling
    '{'{32'd250, 1'b1, 12'd500, 12'd500, 12'd500, 12'd400, 12'd400, 12'd400, 1'b0},
      TYPED, IDLE_RESULT},
    '{'{32'd499, 1'b0, 12'd500, 12'd500, 12'd500, 12'd400, 12'd400, 12'd400, 1'b0},
      TYPED, IDLE_RESULT},
    // pen released during sampling
    '{'{32'd500, 1'b0, 12'd500, 12'd500, 12'd500, 12'd400, 12'd400, 12'd400, 1'b1},
      TYPED, IDLE_RESULT},
    '{'{32'd750, 1'b1, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1},
      TYPED, IDLE_RESULT},
    // full-scale samples
    '{'{32'd1000, 1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b0},
      PREDICT, IDLE_RESULT},
    // step back, step forward, select, then outside the zones
    '{'{32'd1250, 1'b0, 12'd500, 12'd500, 12'd500, 12'd400, 12'd400, 12'd400, 1'b0},
      PREDICT, IDLE_RESULT},
    '{'{32'd1500, 1'b0, 12'd1000, 12'd1000, 12'd1000, 12'd400, 12'd400, 12'd400, 1'b0},
      PREDICT, IDLE_RESULT},
    '{'{32'd1750, 1'b0, 12'd1600, 12'd1600, 12'd1600, 12'd400, 12'd400, 12'd400, 1'b0},
      PREDICT, IDLE_RESULT},
    '{'{32'd2000, 1'b0, 12'd2000, 12'd2000, 12'd2000, 12'd400, 12'd400, 12'd400, 1'b0},
      PREDICT, IDLE_RESULT},
    // closest pair a-b, a-c, b-c
    '{'{32'd2250, 1'b0, 12'd100, 12'd104, 12'd300, 12'd500, 12'd505, 12'd900, 1'b0},
      PREDICT, IDLE_RESULT},
    '{'{32'd2500, 1'b0, 12'd100, 12'd300, 12'd103, 12'd900, 12'd500, 12'd504, 1'b0},
      PREDICT, IDLE_RESULT},
    '{'{32'd2750, 1'b0, 12'd3000, 12'd100, 12'd102, 12'd0, 12'd4000, 12'd4001, 1'b0},
      PREDICT, IDLE_RESULT},
    // ties: a-b equals a-c on x, a-c equals b-c on y
    '{'{32'd3000, 1'b0, 12'd200, 12'd210, 12'd190, 12'd100, 12'd120, 12'd110, 1'b0},
      PREDICT, IDLE_RESULT},
    // odd sums and extreme spread
    '{'{32'd3250, 1'b0, 12'hFFF, 12'hFFE, 12'd0, 12'd1, 12'd0, 12'hFFF, 1'b0},
      PREDICT, IDLE_RESULT},
    // deadline wraps past 2^32
    '{'{32'hFFFF_FFF0, 1'b0, 12'd2048, 12'd2050, 12'd2049, 12'd300, 12'd3000, 12'd310, 1'b0},
      PREDICT, IDLE_RESULT},
    '{'{32'h0000_0100, 1'b0, 12'd700, 12'd710, 12'd705, 12'd350, 12'd351, 12'd352, 1'b0},
      PREDICT, IDLE_RESULT},
    '{'{32'h0000_01F9, 1'b0, 12'd700, 12'd710, 12'd705, 12'd350, 12'd351, 12'd352, 1'b0},
      TYPED, IDLE_RESULT},
    '{'{32'hFFFF_FFFF, 1'b1, 12'd1, 12'd2, 12'd3, 12'd4, 12'd5, 12'd6, 1'b0},
      TYPED, IDLE_RESULT},
    // poll exactly on the wrapped deadline
    '{'{32'h0000_00F9, 1'b0, 12'd1, 12'd2, 12'd3, 12'hFFE, 12'hFFF, 12'hFFD, 1'b0},
      PREDICT, IDLE_RESULT}
  };

  logic clk;
  logic rst;

  logic                           s_tvalid;
  logic                           s_tready;
  logic [tbd_pkg::IN_DATA_W-1:0]  s_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [tbd_pkg::OUT_DATA_W-1:0] m_tdata;

  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [tbd_pkg::APB_ADDR_W-1:0] paddr;
  logic [tbd_pkg::APB_DATA_W-1:0] pwdata;
  logic [tbd_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  // predictor copy of the block's registers and deadline
  logic [15:0] cal_x_gain;
  logic [15:0] cal_x_offset;
  logic [15:0] cal_y_gain;
  logic [15:0] cal_y_offset;
  logic [15:0] hold_off;
  logic [31:0] deadline_ms;

  result_t     pending_results[$];
  int          fail_count;
  int          burst_left;
  logic [31:0] poll_clock_ms;
  bit          long_stall_req;

  touch_button_decoder_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // average of the two samples closest together, first pair wins ties
  function automatic logic [11:0] pick_pair(logic [11:0] a, logic [11:0] b, logic [11:0] c);
    logic [11:0] d_ab;
    logic [11:0] d_ac;
    logic [11:0] d_bc;
    logic [12:0] sum;
    d_ab = (a > b) ? a - b : b - a;
    d_ac = (a > c) ? a - c : c - a;
    d_bc = (b > c) ? b - c : c - b;
    if (d_ab <= d_ac && d_ab <= d_bc) begin
      sum = {1'b0, a} + {1'b0, b};
    end else if (d_ac <= d_bc) begin
      sum = {1'b0, a} + {1'b0, c};
    end else begin
      sum = {1'b0, b} + {1'b0, c};
    end
    return sum[12:1];
  endfunction

  // wrapped 32-bit product, upper half plus offset
  function automatic logic [15:0] calibrate(logic [11:0] raw, logic [15:0] gain,
                                            logic [15:0] offset);
    logic [31:0] prod;
    prod = {20'd0, raw} * {{16{gain[15]}}, gain};
    return prod[31:16] + offset;
  endfunction

  // result of one accepted poll; moves the deadline like the block does
  function automatic result_t decode_poll(poll_t p);
    result_t     r;
    logic [15:0] gx, ox, gy, oy;
    int          cal_sum;
    r = IDLE_RESULT;
    if (p.now_ms < deadline_ms) return r;
    deadline_ms = p.now_ms + {16'd0, hold_off};
    if (p.pen_up_before || p.pen_up_after) return r;
    cal_sum = int'($signed(cal_x_gain)) + int'($signed(cal_x_offset));
    if (cal_sum == 0) begin
      gx = FALLBACK_X_GAIN;
      ox = FALLBACK_X_OFFSET;
      gy = FALLBACK_Y_GAIN;
      oy = FALLBACK_Y_OFFSET;
    end else begin
      gx = cal_x_gain;
      ox = cal_x_offset;
      gy = cal_y_gain;
      oy = cal_y_offset;
    end
    r.x_pos = calibrate(pick_pair(p.x_a, p.x_b, p.x_c), gx, ox);
    r.y_pos = calibrate(pick_pair(p.y_a, p.y_b, p.y_c), gy, oy);
    if (r.y_pos >= BAND_Y_MIN && r.y_pos <= BAND_Y_MAX) begin
      if (r.x_pos > 16'd20 && r.x_pos < 16'd99) begin
        r.action = tbd_pkg::ACT_BACK;
      end else if (r.x_pos > 16'd120 && r.x_pos < 16'd199) begin
        r.action = tbd_pkg::ACT_FWD;
      end else if (r.x_pos > 16'd220 && r.x_pos < 16'd299) begin
        r.action = tbd_pkg::ACT_SELECT;
      end
    end
    return r;
  endfunction

  // three samples around a center, now and then pure noise
  function automatic logic [35:0] sample_triple(int center);
    logic [35:0] t;
    int          spread;
    int          v;
    if ($urandom_range(0, 9) == 0) return {12'($urandom), 12'($urandom), 12'($urandom)};
    spread = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 24);
    for (int i = 0; i < 3; i++) begin
      v = center + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      else if (v > 4095) v = 4095;
      t[i*12 +: 12] = v[11:0];
    end
    return t;
  endfunction

  // next random poll; time mostly moves past the hold-off
  function automatic poll_t make_poll();
    poll_t       p;
    int unsigned roll;
    logic [35:0] xs;
    logic [35:0] ys;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      poll_clock_ms += hold_off + $urandom_range(0, 50);
    end else if (roll < 85) begin
      if (hold_off != 0) poll_clock_ms += $urandom_range(0, hold_off - 1);
    end else if (roll < 93) begin
      poll_clock_ms = $urandom;
    end else begin
      poll_clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
    end
    case ($urandom_range(0, 2))
      0:       xs = sample_triple($urandom_range(0, 4095));
      1:       xs = sample_triple($urandom_range(0, 700));
      default: xs = sample_triple($urandom_range(240, 1700));
    endcase
    case ($urandom_range(0, 2))
      0:       ys = sample_triple($urandom_range(0, 4095));
      1:       ys = sample_triple($urandom_range(240, 560));
      default: ys = sample_triple($urandom_range(300, 480));
    endcase
    p.now_ms = poll_clock_ms;
    if ($urandom_range(0, 4) != 0) begin
      p.pen_up_before = 1'b0;
      p.pen_up_after  = 1'b0;
    end else begin
      p.pen_up_before = 1'($urandom_range(0, 1));
      p.pen_up_after  = 1'($urandom_range(0, 1));
    end
    {p.x_c, p.x_b, p.x_a} = xs;
    {p.y_c, p.y_b, p.y_a} = ys;
    return p;
  endfunction

  // offer one poll request; bursts of random length with random gaps
  task automatic offer_poll(input poll_t p, input bit typed, input result_t want);
    result_t r;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, p.pen_up_after, p.y_c, p.y_b, p.y_a, p.x_c, p.x_b, p.x_a,
                 p.pen_up_before, p.now_ms};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // accepted at this edge: predict in acceptance order
    r = decode_poll(p);
    pending_results.push_back(typed ? want : r);
    burst_left--;
  endtask

  // stop offering and let every pending result drain out
  task automatic wait_idle();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // apb write: setup then access, register taken when pready is high
  task automatic write_reg(input tbd_pkg::reg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      tbd_pkg::REG_X_GAIN:   cal_x_gain   = val;
      tbd_pkg::REG_X_OFFSET: cal_x_offset = val;
      tbd_pkg::REG_Y_GAIN:   cal_y_gain   = val;
      tbd_pkg::REG_Y_OFFSET: cal_y_offset = val;
      tbd_pkg::REG_HOLD_OFF: hold_off     = val;
      default: ;
    endcase
  endtask

  task automatic program_cal(input logic [15:0] xg, input logic [15:0] xo,
                             input logic [15:0] yg, input logic [15:0] yo,
                             input logic [15:0] hold);
    write_reg(tbd_pkg::REG_X_GAIN, xg);
    write_reg(tbd_pkg::REG_X_OFFSET, xo);
    write_reg(tbd_pkg::REG_Y_GAIN, yg);
    write_reg(tbd_pkg::REG_Y_OFFSET, yo);
    write_reg(tbd_pkg::REG_HOLD_OFF, hold);
  endtask

  // result side: stall pattern of its own, plus the long hold-off on request
  initial begin : result_sink
    sink_mode_e mode;
    int         mode_left;
    int         stall_count;
    m_tready  <= 1'b0;
    mode      = SINK_OPEN;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        m_tready <= 1'b0;
        for (stall_count = 0; stall_count < LONG_STALL; stall_count++) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          SINK_OPEN:   m_tready <= 1'b1;
          SINK_COIN:   m_tready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
          default:     m_tready <= (mode_left % 3 != 0);
        endcase
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with none pending: tdata %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[1:0] !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, m_tdata[1:0]);
          fail_count++;
        end
        if (m_tdata[17:2] !== want.x_pos) begin
          $error("x_position: expected %0d, got %0d", want.x_pos, m_tdata[17:2]);
          fail_count++;
        end
        if (m_tdata[33:18] !== want.y_pos) begin
          $error("y_position: expected %0d, got %0d", want.y_pos, m_tdata[33:18]);
          fail_count++;
        end
        if (m_tdata[39:34] !== 6'd0) begin
          $error("pad: expected 0, got %0d", m_tdata[39:34]);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    poll_t p;
    int    per_phase;
    rst            <= 1'b1;
    s_tvalid       <= 1'b0;
    s_tdata        <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    long_stall_req = 1'b0;
    fail_count     = 0;
    burst_left     = 0;
    // reset values of the block
    cal_x_gain     = 16'd0;
    cal_x_offset   = 16'd0;
    cal_y_gain     = 16'd0;
    cal_y_offset   = 16'd0;
    hold_off       = 16'd250;
    deadline_ms    = 32'd0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table under reset calibration
    foreach (DIRECTED[i]) begin
      offer_poll(DIRECTED[i].poll, DIRECTED[i].typed, DIRECTED[i].want);
    end
    poll_clock_ms = 32'h0000_1000;

    // random phases, each under its own calibration
    per_phase = RANDOM_POLLS / PHASES;
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase != 0) begin
        wait_idle();
        case (phase)
          // near half scale on both axes, no hold-off: sweeps zone edges
          1: program_cal(16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
          // most negative and most positive values, longest hold-off
          2: program_cal(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF);
          // nonzero pair that sums to zero still selects the fallback
          3: program_cal(16'd100, 16'hFF9C, 16'($urandom), 16'($urandom), 16'd1);
          // zero gain: position is the offset alone
          4: program_cal(16'd0, 16'($urandom_range(1, 320)), 16'd0,
                         16'($urandom_range(170, 240)), 16'($urandom_range(0, 300)));
          default: program_cal(16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom), 16'($urandom_range(0, 500)));
        endcase
      end
      for (int k = 0; k < per_phase; k++) begin
        // receiver holds off while requests keep coming
        if (k == 40) long_stall_req = 1'b1;
        // sender pauses until everything is out
        if (k == 110) wait_idle();
        p = make_poll();
        offer_poll(p, PREDICT, IDLE_RESULT);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
